// ===== rtl/mpb_pkg.sv =====
// ----------------------------------------------------------------------------
// mpb_pkg
// Shared types and constants for the controller port bridge to shared RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package mpb_pkg;

  // Shared RAM size; the 8-bit address fields cover it exactly
  localparam int MPB_RAM_DEPTH = 256;

  // Bus access codes
  typedef enum logic [2:0] {
    OP_RD_A    = 3'd0,
    OP_WR_A    = 3'd1,
    OP_DDR_A   = 3'd2,
    OP_RD_B    = 3'd3,
    OP_WR_B    = 3'd4,
    OP_DDR_B   = 3'd5,
    OP_HOST_RD = 3'd6,
    OP_HOST_WR = 3'd7
  } mpb_op_t;

  // Port B control bit positions
  localparam int BIT_LATCH_EN = 0;
  localparam int BIT_ADDR_LD  = 1;
  localparam int BIT_RAM_SEL  = 2;
  localparam int BIT_STROBE   = 3;
  localparam int BIT_READ_DIR = 4;
  localparam int BIT_IRQ      = 5;

  // One accepted access
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_value;
    logic [7:0] host_address;
    logic [7:0] input_port_one;
    logic [7:0] input_port_two;
  } mpb_item_t;

  // Shared RAM access request, one per cycle
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mpb_ram_req_t;

  // Result fields known at accept time
  typedef struct packed {
    logic       from_ram;
    logic [7:0] read_data;
    logic       irq_request;
  } mpb_result_t;

endpackage

`default_nettype wire

// ===== rtl/mpb_if.sv =====
// ----------------------------------------------------------------------------
// mpb_in_if / mpb_out_if
// Valid/ready channels carrying bus accesses in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] write_value;
  logic [7:0] host_address;
  logic [7:0] input_port_one;
  logic [7:0] input_port_two;

  modport source (
    output valid, opcode, write_value, host_address, input_port_one, input_port_two,
    input  ready
  );
  modport sink (
    input  valid, opcode, write_value, host_address, input_port_one, input_port_two,
    output ready
  );
endinterface

interface mpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_request;
  logic [7:0] irq_vector;

  modport source (
    output valid, read_data, irq_request, irq_vector,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq_request, irq_vector,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/mpb_ram.sv =====
// ----------------------------------------------------------------------------
// mpb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpb_store.sv =====
// ----------------------------------------------------------------------------
// mpb_store
// Shared RAM with per-byte valid bits (unwritten bytes read as zero) and a
// mirror of byte zero for the interrupt vector.
// ----------------------------------------------------------------------------
`default_nettype none

module mpb_store #(
  parameter int RAM_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mpb_pkg::mpb_ram_req_t req,
  output logic [7:0]                 ram_value,
  output logic [7:0]                 byte0_next
);
  import mpb_pkg::*;

  localparam int AW = $clog2(RAM_DEPTH);

  logic [RAM_DEPTH-1:0] written;
  logic                 rd_written;
  logic [7:0]           rdata;
  logic [7:0]           byte0;

  mpb_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.addr[AW-1:0]),
    .wdata (req.wdata),
    .re    (req.rd_en),
    .raddr (req.addr[AW-1:0]),
    .rdata (rdata)
  );

  // Valid bits stand in for the cleared RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written <= written[req.addr[AW-1:0]];
      end
    end
  end

  assign ram_value = rd_written ? rdata : 8'h00;

  // Byte zero copy, including a write made by the same access
  always_comb begin
    byte0_next = byte0;
    if (req.wr_en && req.addr == 8'h00) begin
      byte0_next = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte0 <= 8'h00;
    end else begin
      byte0 <= byte0_next;
    end
  end

  // A read of a byte written by the previous access returns that byte
  assert property (@(posedge clk) disable iff (rst)
    req.wr_en ##1 (req.rd_en && req.addr == $past(req.addr))
    |=> ram_value == $past(req.wdata, 2))
    else $error("mpb_store: read after write returned stale data");

endmodule

`default_nettype wire

// ===== rtl/mpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpb_ctrl
// Port registers, direction mixing and port B edge decoding; issues the
// shared RAM access for each item that needs one.
// ----------------------------------------------------------------------------
`default_nettype none

module mpb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire mpb_pkg::mpb_item_t     item,
  input  wire logic                   cfg_wr_en,
  input  wire logic [7:0]             cfg_wr_data,
  input  wire logic [7:0]             ram_value,
  output mpb_pkg::mpb_ram_req_t       ram_req,
  output mpb_pkg::mpb_result_t        result
);
  import mpb_pkg::*;

  logic [7:0] port_b_pins;
  logic [7:0] port_a_output,    port_a_output_next;
  logic [7:0] port_a_pins,      port_a_pins_next;
  logic [7:0] port_a_direction, port_a_direction_next;
  logic [7:0] port_b_output,    port_b_output_next;
  logic [7:0] port_b_direction, port_b_direction_next;
  logic [7:0] ram_address,      ram_address_next;
  logic [7:0] data_latch,       data_latch_next;
  logic       latch_pend,       latch_pend_next;

  logic [7:0] latch_cur;
  logic [7:0] wv;
  logic [7:0] falls, rises;

  // Data latch loaded from RAM last cycle arrives through the read register
  assign latch_cur = latch_pend ? ram_value : data_latch;

  // Edges on output-enabled port B bits
  assign wv    = item.write_value;
  assign falls = port_b_direction & port_b_output & ~wv;
  assign rises = port_b_direction & ~port_b_output & wv;

  always_comb begin
    port_a_output_next    = port_a_output;
    port_a_pins_next      = port_a_pins;
    port_a_direction_next = port_a_direction;
    port_b_output_next    = port_b_output;
    port_b_direction_next = port_b_direction;
    ram_address_next      = ram_address;
    data_latch_next       = latch_cur;
    latch_pend_next       = 1'b0;
    ram_req               = '0;
    result                = '0;
    if (accept) begin
      case (mpb_op_t'(item.opcode))
        OP_RD_A: begin
          result.read_data = (port_a_output & port_a_direction)
                           | (port_a_pins & ~port_a_direction);
        end
        OP_WR_A: begin
          port_a_output_next = wv;
        end
        OP_DDR_A: begin
          port_a_direction_next = wv;
        end
        OP_RD_B: begin
          result.read_data = (port_b_output & port_b_direction)
                           | (port_b_pins & ~port_b_direction);
        end
        OP_WR_B: begin
          if (falls[BIT_LATCH_EN]) begin
            port_a_pins_next = latch_cur;
          end
          if (rises[BIT_ADDR_LD]) begin
            ram_address_next = port_a_output;
          end
          if (falls[BIT_STROBE]) begin
            ram_req.addr = ram_address_next;
            if (wv[BIT_READ_DIR]) begin
              if (wv[BIT_RAM_SEL]) begin
                ram_req.rd_en   = 1'b1;
                latch_pend_next = 1'b1;
              end else begin
                data_latch_next = ram_address_next[0] ? item.input_port_two
                                                      : item.input_port_one;
              end
            end else begin
              ram_req.wr_en = 1'b1;
              ram_req.wdata = port_a_output;
            end
          end
          result.irq_request = rises[BIT_IRQ];
          port_b_output_next = wv;
        end
        OP_DDR_B: begin
          port_b_direction_next = wv;
        end
        OP_HOST_RD: begin
          ram_req.rd_en   = 1'b1;
          ram_req.addr    = item.host_address;
          result.from_ram = 1'b1;
        end
        OP_HOST_WR: begin
          ram_req.wr_en = 1'b1;
          ram_req.addr  = item.host_address;
          ram_req.wdata = wv;
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  // Port state
  always_ff @(posedge clk) begin
    if (rst) begin
      port_b_pins      <= 8'hFF;
      port_a_output    <= 8'h00;
      port_a_pins      <= 8'h00;
      port_a_direction <= 8'h00;
      port_b_output    <= 8'h00;
      port_b_direction <= 8'h00;
      ram_address      <= 8'h00;
      data_latch       <= 8'h00;
      latch_pend       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        port_b_pins <= cfg_wr_data;
      end
      port_a_output    <= port_a_output_next;
      port_a_pins      <= port_a_pins_next;
      port_a_direction <= port_a_direction_next;
      port_b_output    <= port_b_output_next;
      port_b_direction <= port_b_direction_next;
      ram_address      <= ram_address_next;
      data_latch       <= data_latch_next;
      latch_pend       <= latch_pend_next;
    end
  end

  // A pending latch load always follows a RAM read
  assert property (@(posedge clk) disable iff (rst)
    latch_pend |-> $past(ram_req.rd_en))
    else $error("mpb_ctrl: latch pending without RAM read");

  // One access never reads and writes the RAM together
  assert property (@(posedge clk) disable iff (rst)
    !(ram_req.rd_en && ram_req.wr_en))
    else $error("mpb_ctrl: RAM read and write in one access");

endmodule

`default_nettype wire

// ===== rtl/mcu_port_bridge_to_shared_ram.sv =====
// ----------------------------------------------------------------------------
// mcu_port_bridge_to_shared_ram
// Bridges a controller's ports A and B to a 256-byte shared RAM with host
// access and a host interrupt.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one bus access per item: opcode, write value, host address and
//          the two external input port levels.
//   rsp  - one result per item: read data, interrupt request and vector.
//   cfg_wr_en / cfg_wr_data - write the port B pin levels (reset 0xFF).
// Each result shows in the cycle after accept; one item per cycle is taken
// while rsp is ready. The result register and the registered RAM read form
// the single stage; a RAM byte loaded into the data latch is forwarded to the
// next item. Reset clears the port registers, sets port B pins to 0xFF and
// marks all RAM bytes unwritten; RAM reads zero at once with no clearing pass.
// When rsp stalls the result and RAM read data hold; req.ready follows
// rsp.ready, so a new item enters in the cycle the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mcu_port_bridge_to_shared_ram #(
  parameter int RAM_DEPTH = mpb_pkg::MPB_RAM_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  mpb_in_if.sink          req,
  mpb_out_if.source       rsp,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);
  import mpb_pkg::*;

  logic         accept;
  mpb_item_t    item;
  mpb_ram_req_t ram_req;
  mpb_result_t  result;
  logic [7:0]   ram_value;
  logic [7:0]   byte0_next;

  logic         out_valid;
  mpb_result_t  res;
  logic [7:0]   vector;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign item.opcode         = req.opcode;
  assign item.write_value    = req.write_value;
  assign item.host_address   = req.host_address;
  assign item.input_port_one = req.input_port_one;
  assign item.input_port_two = req.input_port_two;

  mpb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_value   (ram_value),
    .ram_req     (ram_req),
    .result      (result)
  );

  mpb_store #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (ram_req),
    .ram_value  (ram_value),
    .byte0_next (byte0_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res    <= result;
      vector <= result.irq_request ? byte0_next : 8'h00;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_data   = res.from_ram ? ram_value : res.read_data;
  assign rsp.irq_request = res.irq_request;
  assign rsp.irq_vector  = vector;

  // No vector without an interrupt
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.irq_request |-> rsp.irq_vector == 8'h00)
    else $error("mpb: vector set without interrupt");

endmodule

`default_nettype wire
